FILE: design/rmd_pkg.sv
package rmd_pkg;

  localparam logic [31:0] INIT_WORDS [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

  localparam logic [3:0] SEL_LEFT [80] = '{
    4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
    4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
    4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
    4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
    4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};

  localparam logic [3:0] SEL_RIGHT [80] = '{
    4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
    4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
    4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
    4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
    4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};

  localparam logic [3:0] ROT_LEFT [80] = '{
    4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
    4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
    4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
    4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
    4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};

  localparam logic [3:0] ROT_RIGHT [80] = '{
    4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
    4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
    4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
    4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
    4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};

  localparam logic [31:0] ADD_LEFT [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
  localparam logic [31:0] ADD_RIGHT [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } rmd_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] bool_fn(input logic [2:0] g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    unique case (g)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

FILE: design/rmd_round.sv
module rmd_round
  import rmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rmd_ctl_t    ctl_in,
  input  logic [31:0] cv_in [5],
  input  logic [31:0] w_left,
  input  logic [31:0] w_right,
  output logic [6:0]  step,
  output rmd_ctl_t    ctl_out,
  output logic [31:0] cv_out [5]
);

  logic [31:0] l [5];
  logic [31:0] r [5];
  logic [31:0] tl, tr;
  logic [2:0]  g;
  logic        running;
  logic        done;

  assign g = 3'(step >> 4);

  always_comb begin
    tl = rotl(l[0] + bool_fn(g, l[1], l[2], l[3]) + w_left + ADD_LEFT[g],
              {1'b0, ROT_LEFT[step]}) + l[4];
    tr = rotl(r[0] + bool_fn(3'd4 - g, r[1], r[2], r[3]) + w_right + ADD_RIGHT[g],
              {1'b0, ROT_RIGHT[step]}) + r[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (ctl_in.start) begin
      running <= 1'b1;
      step <= '0;
      done <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        l[i] <= cv_in[i];
        r[i] <= cv_in[i];
      end
    end else if (running) begin
      l[0] <= l[4]; l[4] <= l[3]; l[3] <= rotl(l[2], 5'd10); l[2] <= l[1]; l[1] <= tl;
      r[0] <= r[4]; r[4] <= r[3]; r[3] <= rotl(r[2], 5'd10); r[2] <= r[1]; r[1] <= tr;
      if (step == 7'd79) begin
        running <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + 7'd1;
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign ctl_out = '{start: 1'b0, busy: running, done: done};

  always_comb begin
    cv_out[0] = cv_in[1] + l[2] + r[3];
    cv_out[1] = cv_in[2] + l[3] + r[4];
    cv_out[2] = cv_in[3] + l[4] + r[0];
    cv_out[3] = cv_in[4] + l[0] + r[1];
    cv_out[4] = cv_in[0] + l[1] + r[2];
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= 7'd79)
    else $error("round step out of range");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    ctl_out.done |-> $past(step) == 7'd79)
    else $error("done without final step");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl_in.start |-> !running)
    else $error("start while running");
`endif

endmodule

FILE: design/ripemd160_hash.sv
// RIPEMD-160 hash of a byte stream.
// Input transactions on s_axis: tdata[7:0] is the message byte, tuser[0] says
// that the byte is present and tlast ends the message (it may carry no byte).
// Output transactions on m_axis: tdata[31:0] is a digest word, tuser[2:0]
// its index 0 to 4, and tlast marks the fifth word.
// A byte that does not fill the block is written to the block memory and input
// stays open. A byte that fills the block starts the compression: a launch, a
// load, 80 round steps with both lines in parallel and a fold of the chaining
// value, and input is refused until the fold is done.
// An end of message writes the padding into the block memory at one byte per
// cycle, then compresses once or twice, and offers the five words in order.
// The block memory has one byte write port and is kept in two copies, each with
// one 32-bit word read port; the round unit reads one word per line per step.
// Input is refused while padding, compressing or presenting the digest; a
// stalled receiver holds the current word. Reset restores the initial
// chaining value and clears the byte count; the block memory needs no clearing.
module ripemd160_hash
  import rmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // byte_present
  input  logic        s_axis_tlast,  // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // digest_word
  output logic [2:0]  m_axis_tuser,  // word_index
  output logic        m_axis_tlast   // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;

  logic [2:0]  state;
  logic [60:0] byte_count;
  logic [5:0]  pad_pos;
  logic        final_block, pad_first, pad_wrap;
  logic [31:0] cv [5];
  logic [31:0] cv_new [5];
  logic [31:0] mem_l [16];
  logic [31:0] mem_r [16];
  logic [31:0] w_left, w_right;
  logic [6:0]  step;
  logic [6:0]  step_next;
  logic [6:0]  step_rd;
  logic [2:0]  out_idx;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [63:0] bits;
  rmd_ctl_t    ctl_in, ctl_out;
  logic        acc;

  assign s_axis_tready = (state == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign bits = {byte_count, 3'b000};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = byte_count[5:0];
    wr_data = s_axis_tdata;
    if (acc && s_axis_tuser) begin
      wr_en = 1'b1;
    end else if (state == S_PAD || state == S_LEN) begin
      wr_en = 1'b1;
      wr_addr = pad_pos;
      if (pad_first) wr_data = 8'h80;
      else if (state == S_LEN) wr_data = bits[8*pad_pos[2:0] +: 8];
      else wr_data = 8'h00;
    end
  end

  // Read address follows the round step of the next cycle.
  assign step_next = ctl_in.start ? 7'd0 : (ctl_out.busy ? step + 7'd1 : step);
  assign step_rd = (step_next > 7'd79) ? 7'd79 : step_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_l[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
      mem_r[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
    end
    w_left <= mem_l[SEL_LEFT[step_rd]];
    w_right <= mem_r[SEL_RIGHT[step_rd]];
  end

  rmd_round u_round (
    .clk(clk), .rst(rst), .ctl_in(ctl_in), .cv_in(cv), .w_left(w_left),
    .w_right(w_right), .step(step), .ctl_out(ctl_out), .cv_out(cv_new)
  );

  logic launched;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      pad_pos <= '0;
      pad_first <= 1'b0;
      pad_wrap <= 1'b0;
      final_block <= 1'b0;
      launched <= 1'b0;
      ctl_in <= '0;
      out_idx <= '0;
      for (int i = 0; i < 5; i++) cv[i] <= INIT_WORDS[i];
    end else begin
      ctl_in.start <= (state == S_COMP) && !launched;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (s_axis_tuser) byte_count <= byte_count + 61'd1;
            if (s_axis_tuser && byte_count[5:0] == 6'd63) begin
              state <= S_COMP;
              launched <= 1'b0;
              final_block <= 1'b0;
              pad_first <= s_axis_tlast;
            end else if (s_axis_tlast) begin
              state <= S_PAD;
              pad_first <= 1'b1;
              pad_pos <= byte_count[5:0] + 6'(s_axis_tuser);
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (pad_pos == 6'd55) begin
            state <= S_LEN;
            pad_pos <= 6'd56;
          end else if (pad_pos == 6'd63) begin
            state <= S_COMP;
            launched <= 1'b0;
            final_block <= 1'b0;
            pad_wrap <= 1'b1;
            pad_pos <= 6'd0;
          end else begin
            pad_pos <= pad_pos + 6'd1;
          end
        end
        S_LEN: begin
          pad_first <= 1'b0;
          if (pad_pos == 6'd63) begin
            state <= S_COMP;
            launched <= 1'b0;
            final_block <= 1'b1;
          end else begin
            pad_pos <= pad_pos + 6'd1;
          end
        end
        S_COMP: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (ctl_out.done) begin
            for (int i = 0; i < 5; i++) cv[i] <= cv_new[i];
            if (final_block) begin
              state <= S_OUT;
              out_idx <= '0;
            end else if (pad_first || pad_wrap) begin
              state <= S_PAD;
              pad_pos <= 6'd0;
              pad_wrap <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (out_idx == 3'd4) begin
              state <= S_IDLE;
              byte_count <= '0;
              for (int i = 0; i < 5; i++) cv[i] <= INIT_WORDS[i];
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = cv[out_idx];
  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == 3'd4);

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_out.busy |-> !s_axis_tready)
    else $error("input taken during compression");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_idx <= 3'd4)
    else $error("digest index out of range");
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> byte_count == 61'd0)
    else $error("byte count not cleared after digest");
`endif

endmodule
